FILE: rtl/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_MULT = 32'd16777619;

    localparam int          LIMIT_W     = 11;
    localparam logic [10:0] LIMIT_RESET = 11'd717;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [10:0] entries_held;
    } res_t;

endpackage

FILE: rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lpht_fnv.sv
// FNV-1a over the four key bytes, one byte per cycle, giving the home slot.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_fnv
    import lpht_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [31:0]   key,
    output logic          done,
    output logic [AW-1:0] home
);

    logic        run_reg;
    logic        done_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic [31:0] h_mix;

    assign h_mix = 32'((h_reg ^ {24'd0, k_reg[7:0]}) * HASH_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            h_reg <= FNV_BASIS;
            k_reg <= key;
        end
        else if (run_reg)
        begin
            h_reg <= h_mix;
            k_reg <= k_reg >> 8;
        end
    end

    assign done = done_reg;
    assign home = h_reg[AW-1:0];

endmodule

FILE: rtl/linear_probe_hash_table_core.sv
// Top level of the linear-probe hash table: request sequencer and slot memory.
// Depends on lpht_pkg, lpht_ram, lpht_fnv.
`timescale 1ns / 1ps
//
// Usage:
//   A request (lookup, insert-or-update or delete of a 32-bit key) is taken
//   on a clock edge with start high and busy low. Exactly one result follows,
//   shown on result for the single cycle that done is high; the receiver
//   cannot stall it, so it must sample in that cycle. load_limit must be
//   written with load_limit_we/load_limit_wdata only while idle; the block
//   itself does not enforce this.
// Operation:
//   Hashing runs on the shared FNV unit; each probe is a memory read plus a
//   compare. A delete frees the slot, then rehashes and replaces each entry
//   of the following cluster. One request at a time.
// Reset:
//   After rst_n rises a clearing pass over all SLOTS slots empties the memory;
//   busy stays high until it ends. entry count resets to zero, load_limit
//   to 717.
// SLOTS must be a power of two.

module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 request,
    output logic                 done,
    output res_t                 result,
    input  logic                 load_limit_we,
    input  logic [LIMIT_W-1:0]   load_limit_wdata
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int VW = VALUE_BITS;
    localparam int EW = 1 + 32 + VW;
    localparam logic [AW-1:0] LAST = {AW{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_FRD, S_FCHK,
        S_DRD, S_DCHK, S_DHASH, S_PRD, S_PCHK, S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          act_reg, act_next;
    logic [31:0]         key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       n_reg, n_next;
    logic [AW-1:0]       ci_reg, ci_next;
    logic [AW-1:0]       cn_reg, cn_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [31:0]         mk_reg, mk_next;
    logic [VW-1:0]       mv_reg, mv_next;
    logic [1:0]          status_reg, status_next;
    logic [VW-1:0]       vout_reg, vout_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                done_reg, done_next;
    res_t                result_reg, result_next;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [EW-1:0]       wdata, rdata;
    logic                r_used;
    logic [31:0]         r_key;
    logic [VW-1:0]       r_val;
    logic                hash_go, hash_done;
    logic [31:0]         hash_key;
    logic [AW-1:0]       hash_home;
    logic                at_limit;

    lpht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lpht_fnv #(.AW(AW)) u_fnv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (hash_go),
        .key   (hash_key),
        .done  (hash_done),
        .home  (hash_home)
    );

    assign r_used   = rdata[EW-1];
    assign r_key    = rdata[EW-2 -: 32];
    assign r_val    = rdata[VW-1:0];
    assign at_limit = LW'(count_reg) >= LW'(limit_reg);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        n_next      = n_reg;
        ci_next     = ci_reg;
        cn_next     = cn_reg;
        clr_next    = clr_reg;
        mk_next     = mk_reg;
        mv_next     = mv_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = '0;
        raddr       = ptr_reg;
        hash_go     = 1'b0;
        hash_key    = key_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = request.action;
                    key_next   = request.key;
                    val_next   = VW'(request.value_in);
                    vout_next  = '0;
                    n_next     = '0;
                    hash_go    = 1'b1;
                    hash_key   = request.key;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    ptr_next = hash_home;
                    if (act_reg == ACT_LOOKUP || act_reg == ACT_INSERT
                        || act_reg == ACT_DELETE)
                    begin
                        state_next = S_FRD;
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_RESP;
                    end
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (r_used && r_key == key_reg)
                begin
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    if (act_reg == ACT_LOOKUP)
                    begin
                        vout_next = r_val;
                    end
                    else if (act_reg == ACT_INSERT)
                    begin
                        we    = 1'b1;
                        wdata = {1'b1, key_reg, val_reg};
                    end
                    else
                    begin
                        // free the slot, then replace the cluster behind it
                        we         = 1'b1;
                        vout_next  = r_val;
                        count_next = count_reg - 1'b1;
                        ci_next    = ptr_reg + 1'b1;
                        cn_next    = '0;
                        state_next = S_DRD;
                    end
                end
                else if (!r_used || n_reg == LAST)
                begin
                    state_next  = S_RESP;
                    status_next = ST_ABSENT;
                    if (act_reg == ACT_INSERT)
                    begin
                        if (at_limit || r_used)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            we          = 1'b1;
                            wdata       = {1'b1, key_reg, val_reg};
                            count_next  = count_reg + 1'b1;
                            status_next = ST_DONE;
                        end
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_DRD:
            begin
                raddr      = ci_reg;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (!r_used)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mk_next    = r_key;
                    mv_next    = r_val;
                    we         = 1'b1;
                    waddr      = ci_reg;
                    hash_go    = 1'b1;
                    hash_key   = r_key;
                    state_next = S_DHASH;
                end
            end
            S_DHASH:
            begin
                if (hash_done)
                begin
                    ptr_next   = hash_home;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!r_used)
                begin
                    we    = 1'b1;
                    wdata = {1'b1, mk_reg, mv_reg};
                    if (cn_reg == LAST)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cn_next    = cn_reg + 1'b1;
                        ci_next    = ci_reg + 1'b1;
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_PRD;
                end
            end
            S_RESP:
            begin
                done_next                = 1'b1;
                result_next.status       = status_reg;
                result_next.value_out    = 32'(vout_reg);
                result_next.entries_held = 11'(count_reg);
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (load_limit_we)
            begin
                limit_reg <= load_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        n_reg      <= n_next;
        ci_reg     <= ci_next;
        cn_reg     <= cn_next;
        mk_reg     <= mk_next;
        mv_reg     <= mv_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= CW'(SLOTS))
        else $error("entry count above slot count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_DONE || result.status == ST_ABSENT
                  || result.status == ST_FULL))
        else $error("bad status code");

endmodule
